// ----- design/pae_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pae_pkg
// Shared types, constants and saturation helpers for the particle
// attractor update block.
// ---------------------------------------------------------------------------
package pae_pkg;

    localparam int MAX_ATTRACTORS_DEF = 8;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int MAG_W = 33;   // |center - pos|, exact
    localparam int SQ_W  = 66;   // dx^2 + dy^2, exact
    localparam int QUO_W = 33;   // quotient bits kept before clipping

    localparam logic [31:0] GAIN_RESET  = 32'd9830400;
    localparam logic [19:0] DT_RESET    = 20'd4551;
    localparam logic [3:0]  COUNT_RESET = 4'd2;

    localparam logic [1:0] REG_GAIN  = 2'd0;
    localparam logic [1:0] REG_DT    = 2'd1;
    localparam logic [1:0] REG_COUNT = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    typedef struct packed {
        logic               action;
        logic [2:0]         attr_index;
        logic signed [31:0] attr_x;
        logic signed [31:0] attr_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
    } center_t;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] q;
    } div_res_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SQ,
        ST_NUM,
        ST_CHK,
        ST_DIVX,
        ST_DIVY,
        ST_NEXT,
        ST_VEL,
        ST_POS,
        ST_DONE
    } state_t;

    // clip a wide signed value to 32 bits
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        r.clip = 1'b0;
        r.val  = v[31:0];
        if (v > 64'sd2147483647) begin
            r.clip = 1'b1;
            r.val  = 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            r.clip = 1'b1;
            r.val  = 32'sh8000_0000;
        end
        return r;
    endfunction

    // signed, clipped force term from quotient magnitude
    function automatic sat_t force_term(input logic [QUO_W-1:0] q, input logic ovf,
                                        input logic neg);
        sat_t r;
        logic [QUO_W-1:0] nq;
        nq     = -q;
        r.clip = 1'b0;
        r.val  = q[31:0];
        if (!neg) begin
            if (ovf || q > 33'd2147483647) begin
                r.clip = 1'b1;
                r.val  = 32'sh7FFF_FFFF;
            end
        end else begin
            if (ovf || q > 33'h0_8000_0000) begin
                r.clip = 1'b1;
                r.val  = 32'sh8000_0000;
            end else begin
                r.val = nq[31:0];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- design/pae_cell.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pae_cell
// One attractor slot of the rotating center ring.
// ---------------------------------------------------------------------------
module pae_cell (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              shift,
    input  wire              load,
    input  pae_pkg::center_t load_val,
    input  pae_pkg::center_t next_val,
    output pae_pkg::center_t val
);
    import pae_pkg::*;

    center_t val_reg;

    // load a new center, or advance the ring by one slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (load)
        begin
            val_reg <= load_val;
        end
        else if (shift)
        begin
            val_reg <= next_val;
        end
    end

    assign val = val_reg;

endmodule
`default_nettype wire

// ----- design/pae_div.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// pae_div
// Restoring divider, one quotient bit per cycle, with early overflow check.
// ---------------------------------------------------------------------------
module pae_div #(
    parameter int NUM_W = 32 + pae_pkg::MAG_W + pae_pkg::FRAC_BITS_DEF
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  [NUM_W-1:0]            num,
    input  wire  [pae_pkg::SQ_W-1:0]    den,
    output pae_pkg::div_res_t           res
);
    import pae_pkg::*;

    localparam int CNT_W = $clog2(QUO_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SQ_W-1:0]  rem_reg;
    logic [SQ_W-1:0]  den_reg;
    logic [QUO_W-1:0] lo_reg;
    logic [QUO_W-1:0] q_reg;
    logic             ovf_reg;

    logic [SQ_W-1:0]  top_ext;
    logic             start_ovf;
    logic [SQ_W:0]    rem_shift;
    logic [SQ_W+1:0]  diff;
    logic             ge;

    assign top_ext   = SQ_W'(num[NUM_W-1:QUO_W]);
    assign start_ovf = (top_ext >= den);
    assign rem_shift = {rem_reg, lo_reg[QUO_W-1]};
    assign diff      = {1'b0, rem_shift} - {2'b00, den_reg};
    assign ge        = !diff[SQ_W+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !start_ovf;
                done_reg <= start_ovf;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= top_ext;
            den_reg <= den;
            lo_reg  <= num[QUO_W-1:0];
            q_reg   <= '0;
            ovf_reg <= start_ovf;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[SQ_W-1:0] : rem_shift[SQ_W-1:0];
            lo_reg  <= {lo_reg[QUO_W-2:0], 1'b0};
            q_reg   <= {q_reg[QUO_W-2:0], ge};
        end
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.q    = q_reg;

endmodule
`default_nettype wire

// ----- design/particle_attractor_euler_step.sv -----
`default_nettype none
// A write transaction loads its table slot. A step transaction walks every table
//   slot through diff, square, numerator, check and next, then updates velocity
//   and position; each active attractor at nonzero distance adds two 33-bit
//   divisions, one quotient bit a cycle; a division whose quotient overflows skips
//   the iterations. One transaction at a time; a single divider serves x and y.
// Reset: config registers return to defaults; every table center clears to zero.
// ---------------------------------------------------------------------------
// particle_attractor_euler_step
// Semi-implicit Euler update of one particle pulled by a ring of point
// attractors, signed fixed point with saturation.
// ---------------------------------------------------------------------------
module particle_attractor_euler_step #(
    parameter int MAX_ATTRACTORS = pae_pkg::MAX_ATTRACTORS_DEF,
    parameter int FRAC_BITS      = pae_pkg::FRAC_BITS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_write,
    input  wire  [1:0]          cfg_index,
    input  wire  [31:0]         cfg_data,
    input  wire                 in_valid,
    output logic                in_stall,
    input  pae_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  wire                 out_stall,
    output pae_pkg::out_item_t  out_data
);
    import pae_pkg::*;

    localparam int NUM_W = 32 + MAG_W + FRAC_BITS;
    localparam int K_W   = $clog2(MAX_ATTRACTORS + 1);

    // configuration
    logic [31:0] gain_reg;
    logic [19:0] dt_reg;
    logic [3:0]  count_reg;

    // control
    state_t      state_reg, state_next;
    logic [K_W-1:0] k_reg;
    logic        out_valid_reg;
    logic        clip_reg;

    // particle payload
    logic signed [31:0] px_reg, py_reg, vx_reg, vy_reg, ax_reg, ay_reg;
    logic               negx_reg, negy_reg;
    logic [MAG_W-1:0]   magx_reg, magy_reg;
    logic [SQ_W-1:0]    sqx_reg, sqy_reg, r_reg;
    logic [NUM_W-1:0]   numx_reg, numy_reg;
    out_item_t          out_data_reg;

    // ring
    center_t ring [MAX_ATTRACTORS];
    center_t head;
    logic    ring_shift;
    logic    wr_en;
    center_t wr_val;

    // divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    div_res_t         div_res;

    // step handshake and control decode
    logic step_take, write_take, active, nonzero, out_load, last_slot;

    assign step_take  = in_valid && !in_stall && (in_data.action == ACT_STEP);
    assign write_take = in_valid && !in_stall && (in_data.action == ACT_WRITE);
    assign active     = (8'(k_reg) < 8'(count_reg));
    assign nonzero    = (r_reg != '0);
    assign last_slot  = (k_reg == K_W'(MAX_ATTRACTORS - 1));
    assign wr_en      = write_take;
    assign wr_val.x   = in_data.attr_x;
    assign wr_val.y   = in_data.attr_y;
    assign head       = ring[0];

    // ring of centers: slot i takes from slot i+1, the head sees entry k
    for (genvar i = 0; i < MAX_ATTRACTORS; i++)
    begin : g_cell
        pae_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .shift    (ring_shift),
            .load     (wr_en && (32'(in_data.attr_index) == i)),
            .load_val (wr_val),
            .next_val (ring[(i + 1) % MAX_ATTRACTORS]),
            .val      (ring[i])
        );
    end

    pae_div #(.NUM_W(NUM_W)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (r_reg),
        .res   (div_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (step_take) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   state_next = ST_NUM;
            ST_NUM:  state_next = ST_CHK;
            ST_CHK:  state_next = (active && nonzero) ? ST_DIVX : ST_NEXT;
            ST_DIVX: if (div_res.done) state_next = ST_DIVY;
            ST_DIVY: if (div_res.done) state_next = ST_NEXT;
            ST_NEXT: state_next = last_slot ? ST_VEL : ST_DIFF;
            ST_VEL:  state_next = ST_POS;
            ST_POS:  state_next = ST_DONE;
            ST_DONE: if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall   = (state_reg != ST_IDLE);
        ring_shift = (state_reg == ST_NEXT);
        div_start  = 1'b0;
        div_num    = numx_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_CHK:  div_start = active && nonzero;
            ST_DIVX:
            begin
                div_start = div_res.done;
                div_num   = numy_reg;
            end
            ST_DONE: out_load = !out_valid_reg || !out_stall;
            default: ;
        endcase
    end

    // datapath comb
    logic signed [32:0] dx, dy;
    logic [64:0]        gmx, gmy;
    sat_t               tx, ty, sax, say;
    logic signed [52:0] pvx, pvy, ppx, ppy;
    sat_t               nvx, nvy, npx, npy;

    assign dx  = {head.x[31], head.x} - {px_reg[31], px_reg};
    assign dy  = {head.y[31], head.y} - {py_reg[31], py_reg};
    assign gmx = 65'(gain_reg) * 65'(magx_reg);
    assign gmy = 65'(gain_reg) * 65'(magy_reg);
    assign tx  = force_term(div_res.q, div_res.ovf, negx_reg);
    assign ty  = force_term(div_res.q, div_res.ovf, negy_reg);
    assign sax = sat32(64'(ax_reg) + 64'(tx.val));
    assign say = sat32(64'(ay_reg) + 64'(ty.val));
    assign pvx = 53'(ax_reg) * $signed({33'd0, dt_reg});
    assign pvy = 53'(ay_reg) * $signed({33'd0, dt_reg});
    assign ppx = 53'(vx_reg) * $signed({33'd0, dt_reg});
    assign ppy = 53'(vy_reg) * $signed({33'd0, dt_reg});
    // arithmetic shift floors toward minus infinity
    assign nvx = sat32(64'(vx_reg) + 64'(pvx >>> FRAC_BITS));
    assign nvy = sat32(64'(vy_reg) + 64'(pvy >>> FRAC_BITS));
    assign npx = sat32(64'(px_reg) + 64'(ppx >>> FRAC_BITS));
    assign npy = sat32(64'(py_reg) + 64'(ppy >>> FRAC_BITS));

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
            clip_reg      <= 1'b0;
            gain_reg      <= GAIN_RESET;
            dt_reg        <= DT_RESET;
            count_reg     <= COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_GAIN:  gain_reg  <= cfg_data;
                    REG_DT:    dt_reg    <= cfg_data[19:0];
                    REG_COUNT: count_reg <= cfg_data[3:0];
                    default:   ;
                endcase
            end
            // advance the slot counter; it wraps home once the ring is back
            if (state_reg == ST_NEXT)
            begin
                k_reg <= last_slot ? '0 : k_reg + 1'b1;
            end
            if (step_take)
            begin
                clip_reg <= 1'b0;
            end
            else if (state_reg == ST_DIVX && div_res.done)
            begin
                clip_reg <= clip_reg | tx.clip | sax.clip;
            end
            else if (state_reg == ST_DIVY && div_res.done)
            begin
                clip_reg <= clip_reg | ty.clip | say.clip;
            end
            else if (state_reg == ST_VEL)
            begin
                clip_reg <= clip_reg | nvx.clip | nvy.clip;
            end
            else if (state_reg == ST_POS)
            begin
                clip_reg <= clip_reg | npx.clip | npy.clip;
            end
            // hold the result until the consumer takes it
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (step_take)
        begin
            px_reg <= in_data.pos_x;
            py_reg <= in_data.pos_y;
            vx_reg <= in_data.vel_x;
            vy_reg <= in_data.vel_y;
            ax_reg <= '0;
            ay_reg <= '0;
        end
        unique case (state_reg)
            ST_DIFF:
            begin
                negx_reg <= dx[32];
                negy_reg <= dy[32];
                magx_reg <= dx[32] ? MAG_W'(-dx) : MAG_W'(dx);
                magy_reg <= dy[32] ? MAG_W'(-dy) : MAG_W'(dy);
            end
            ST_SQ:
            begin
                sqx_reg <= SQ_W'(magx_reg) * SQ_W'(magx_reg);
                sqy_reg <= SQ_W'(magy_reg) * SQ_W'(magy_reg);
            end
            ST_NUM:
            begin
                numx_reg <= {gmx, {FRAC_BITS{1'b0}}};
                numy_reg <= {gmy, {FRAC_BITS{1'b0}}};
                r_reg    <= sqx_reg + sqy_reg;
            end
            ST_DIVX: if (div_res.done) ax_reg <= sax.val;
            ST_DIVY: if (div_res.done) ay_reg <= say.val;
            ST_VEL:
            begin
                vx_reg <= nvx.val;
                vy_reg <= nvy.val;
            end
            ST_POS:
            begin
                px_reg <= npx.val;
                py_reg <= npy.val;
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_data_reg.new_pos_x <= px_reg;
            out_data_reg.new_pos_y <= py_reg;
            out_data_reg.new_vel_x <= vx_reg;
            out_data_reg.new_vel_y <= vy_reg;
            out_data_reg.saturated <= clip_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == ST_DIVX || state_reg == ST_DIVY))
        else $error("divider finished outside a division state");

    a_ring_home: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (k_reg == '0))
        else $error("center ring not at home while idle");

    a_step_starts: assert property (@(posedge clk) disable iff (!rst_n)
        step_take |=> (state_reg == ST_DIFF))
        else $error("step transaction did not start the slot walk");

    a_result_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("finished result not presented");
`endif

endmodule
`default_nettype wire
